FILE: rtl/mcdt_pkg.sv
// shared constants, codes and types of the multi-channel duration timer
// used by every module of the block, depends on nothing
package mcdt_pkg;

  localparam int NUM_CHANNELS = 8;
  localparam int COUNT_WIDTH  = 16;

  localparam int MASK_W     = 8;
  localparam int MODE_W     = 3;
  localparam int CHAN_W     = 3;
  localparam int LOAD_W     = 2;
  localparam int LIMIT_W    = 16;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  localparam logic [LIMIT_W-1:0] HB_LIMIT_RST    = LIMIT_W'(60);
  localparam logic [LIMIT_W-1:0] REPLY_LIMIT_RST = LIMIT_W'(60);

  localparam logic [CFG_IDX_W-1:0] CFG_HB_LIMIT    = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_REPLY_LIMIT = CFG_IDX_W'(1);

  typedef enum logic [MODE_W-1:0] {
    MODE_TICK       = 3'd0,
    MODE_LOAD       = 3'd1,
    MODE_WAIT_START = 3'd2,
    MODE_REPLY      = 3'd3,
    MODE_HB_REARM   = 3'd4
  } mode_e;

  typedef enum logic [LOAD_W-1:0] {
    PWR_OFF     = 2'd0,
    PWR_ON      = 2'd1,
    PWR_UNKNOWN = 2'd2
  } pwr_e;

  // command handed from the input register to the state holders
  typedef struct packed {
    logic                   fire;
    logic [MODE_W-1:0]      mode;
    logic [CHAN_W-1:0]      channel;
    logic [LOAD_W-1:0]      load_state;
    logic [COUNT_WIDTH-1:0] load_total;
    logic                   logged_in;
  } cmd_t;

  // per-channel events of one tick
  typedef struct packed {
    logic [NUM_CHANNELS-1:0] closed;
    logic [NUM_CHANNELS-1:0] counting;
    logic [NUM_CHANNELS-1:0] errors;
  } chan_evt_t;

  // global status after one item
  typedef struct packed {
    logic               beat_rdy;
    logic               waiting;
    logic [LIMIT_W-1:0] reply_count;
    logic               expired;
  } status_t;

endpackage

FILE: rtl/mcdt_chan_bank.sv
// channel bank: power state, duration and elapsed count of every channel
// updated in parallel on a tick, loaded one at a time; uses mcdt_pkg
module mcdt_chan_bank import mcdt_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cmd_t      cmd_i,
  output chan_evt_t evt_o
);

  pwr_e                   power_q [NUM_CHANNELS];
  pwr_e                   power_d [NUM_CHANNELS];
  logic [COUNT_WIDTH-1:0] dur_q   [NUM_CHANNELS];
  logic [COUNT_WIDTH-1:0] dur_d   [NUM_CHANNELS];
  logic [COUNT_WIDTH-1:0] elap_q  [NUM_CHANNELS];
  logic [COUNT_WIDTH-1:0] elap_d  [NUM_CHANNELS];

  logic is_tick;
  logic is_load;
  pwr_e load_pwr;

  assign is_tick  = cmd_i.fire && (cmd_i.mode == MODE_TICK);
  assign is_load  = cmd_i.fire && (cmd_i.mode == MODE_LOAD);
  // code three has no meaning and stores unknown
  assign load_pwr = (cmd_i.load_state == PWR_OFF) ? PWR_OFF :
                    (cmd_i.load_state == PWR_ON)  ? PWR_ON  : PWR_UNKNOWN;

  always_comb begin
    evt_o = '0;
    for (int i = 0; i < NUM_CHANNELS; i++) begin
      power_d[i] = power_q[i];
      dur_d[i]   = dur_q[i];
      elap_d[i]  = elap_q[i];
      if (is_tick) begin
        case (power_q[i])
          PWR_ON: begin
            if (dur_q[i] == '0) begin
              power_d[i]     = PWR_UNKNOWN;
              evt_o.errors[i] = 1'b1;
            end else if (elap_q[i] >= dur_q[i]) begin
              power_d[i]      = PWR_OFF;
              dur_d[i]        = '0;
              elap_d[i]       = '0;
              evt_o.closed[i] = 1'b1;
            end else begin
              elap_d[i]         = elap_q[i] + COUNT_WIDTH'(1);
              evt_o.counting[i] = 1'b1;
            end
          end
          PWR_OFF: begin
            if (dur_q[i] != '0) begin
              power_d[i]      = PWR_UNKNOWN;
              evt_o.errors[i] = 1'b1;
            end
          end
          default: begin
            // unknown channels are left alone
          end
        endcase
      end else if (is_load && (32'(cmd_i.channel) == i)) begin
        power_d[i] = load_pwr;
        dur_d[i]   = COUNT_WIDTH'(cmd_i.load_total);
        elap_d[i]  = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        power_q[i] <= PWR_OFF;
        dur_q[i]   <= '0;
        elap_q[i]  <= '0;
      end
    end else begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        power_q[i] <= power_d[i];
        dur_q[i]   <= dur_d[i];
        elap_q[i]  <= elap_d[i];
      end
    end
  end

endmodule

FILE: rtl/mcdt_status.sv
// heartbeat counter, reply wait counter and flag, and the two limit registers
// uses mcdt_pkg; takes the any-channel-closed event from the channel bank
module mcdt_status import mcdt_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  cmd_t                  cmd_i,
  input  logic                  any_closed_i,
  output status_t               status_o
);

  logic [LIMIT_W-1:0]     hb_limit_q;
  logic [LIMIT_W-1:0]     reply_limit_q;
  logic [COUNT_WIDTH-1:0] hb_count_q, hb_count_d;
  logic                   beat_rdy_q, beat_rdy_d;
  logic [COUNT_WIDTH-1:0] reply_q, reply_d;
  logic                   wait_q, wait_d;

  always_comb begin
    hb_count_d = hb_count_q;
    beat_rdy_d = beat_rdy_q;
    reply_d    = reply_q;
    wait_d     = wait_q;
    if (cmd_i.fire) begin
      case (cmd_i.mode)
        MODE_TICK: begin
          if (!beat_rdy_q) begin
            if (32'(hb_count_q) >= 32'(hb_limit_q)) begin
              beat_rdy_d = 1'b1;
              hb_count_d = '0;
            end else begin
              hb_count_d = hb_count_q + COUNT_WIDTH'(1);
            end
          end
          // a closing channel drops the wait before the reply counter looks at it
          wait_d = wait_q && !any_closed_i;
          if ((wait_d || !cmd_i.logged_in) && (32'(reply_q) < 32'(reply_limit_q))) begin
            reply_d = reply_q + COUNT_WIDTH'(1);
          end
        end
        MODE_WAIT_START: begin
          wait_d  = 1'b1;
          reply_d = '0;
        end
        MODE_REPLY: begin
          wait_d  = 1'b0;
          reply_d = '0;
        end
        MODE_HB_REARM: begin
          beat_rdy_d = 1'b0;
          hb_count_d = '0;
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    status_o.beat_rdy    = beat_rdy_d;
    status_o.waiting     = wait_d;
    status_o.reply_count = LIMIT_W'(reply_d);
    status_o.expired     = (32'(reply_d) >= 32'(reply_limit_q));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hb_limit_q    <= HB_LIMIT_RST;
      reply_limit_q <= REPLY_LIMIT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_HB_LIMIT:    hb_limit_q    <= LIMIT_W'(cfg_data_i);
        CFG_REPLY_LIMIT: reply_limit_q <= LIMIT_W'(cfg_data_i);
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hb_count_q <= '0;
      beat_rdy_q <= 1'b0;
      reply_q    <= '0;
      wait_q     <= 1'b0;
    end else begin
      hb_count_q <= hb_count_d;
      beat_rdy_q <= beat_rdy_d;
      reply_q    <= reply_d;
      wait_q     <= wait_d;
    end
  end

endmodule

FILE: rtl/multi_channel_duration_timer_core.sv
// top level of the multi-channel duration timer: input register, result register
// instantiates mcdt_chan_bank and mcdt_status; uses mcdt_pkg
//
// One item in, one result out. Every item (tick, channel load, reply wait start,
// reply received, heartbeat rearm) is captured in an input register and applied
// to all channels and counters as it moves on into the result register, so the
// block takes one item per clock while the result register is not stalled, and
// a result is on the outputs once its item has passed both registers.
// The result register holds a result while out_stall_i is high; the input
// register still takes a new item then, and in_stall_o rises only when both
// registers are full. The closed, counting and error masks are zero except on
// a tick and cover channels 0 to 7. The user must write the limit registers
// through the cfg port while no item is in flight; the block does not enforce it.
module multi_channel_duration_timer_core import mcdt_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [MODE_W-1:0]     mode_i,
  input  logic [CHAN_W-1:0]     channel_i,
  input  logic [LOAD_W-1:0]     load_state_i,
  input  logic [15:0]           load_total_i,
  input  logic                  logged_in_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [MASK_W-1:0]     closed_now_o,
  output logic [MASK_W-1:0]     counting_now_o,
  output logic [MASK_W-1:0]     error_now_o,
  output logic                  in_task_o,
  output logic                  heartbeat_ready_o,
  output logic                  awaiting_reply_o,
  output logic [LIMIT_W-1:0]    reply_ticks_o,
  output logic                  reply_expired_o
);

  logic                   s1_valid_q, s1_valid_d;
  logic [MODE_W-1:0]      mode_q;
  logic [CHAN_W-1:0]      channel_q;
  logic [LOAD_W-1:0]      load_state_q;
  logic [COUNT_WIDTH-1:0] load_total_q;
  logic                   logged_in_q;

  logic out_valid_q, out_valid_d;
  logic s1_adv;
  logic accept_in;

  cmd_t      cmd;
  chan_evt_t evt;
  status_t   status;

  assign s1_adv     = !out_valid_q || !out_stall_i;
  assign in_stall_o = s1_valid_q && !s1_adv;
  assign accept_in  = in_valid_i && !in_stall_o;
  assign s1_valid_d = accept_in || (s1_valid_q && !s1_adv);
  assign out_valid_d = (s1_valid_q && s1_adv) || (out_valid_q && out_stall_i);

  always_comb begin
    cmd.fire       = s1_valid_q && s1_adv;
    cmd.mode       = mode_q;
    cmd.channel    = channel_q;
    cmd.load_state = load_state_q;
    cmd.load_total = load_total_q;
    cmd.logged_in  = logged_in_q;
  end

  mcdt_chan_bank u_chan_bank (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .evt_o  (evt)
  );

  mcdt_status u_status (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .cmd_i        (cmd),
    .any_closed_i (|evt.closed),
    .status_o     (status)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_in) begin
      mode_q       <= mode_i;
      channel_q    <= channel_i;
      load_state_q <= load_state_i;
      load_total_q <= COUNT_WIDTH'(load_total_i);
      logged_in_q  <= logged_in_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd.fire) begin
      closed_now_o      <= MASK_W'(evt.closed);
      counting_now_o    <= MASK_W'(evt.counting);
      error_now_o       <= MASK_W'(evt.errors);
      in_task_o         <= |evt.counting;
      heartbeat_ready_o <= status.beat_rdy;
      awaiting_reply_o  <= status.waiting;
      reply_ticks_o     <= status.reply_count;
      reply_expired_o   <= status.expired;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule
